// ----- hw/rtl/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg
// shared constants and function codes of the tick phase scheduler
// ----------------------------------------------------------------------------
package tps_pkg;

   // field widths
   localparam int SAMPLE_W    = 16;
   localparam int TIME_W      = 32;
   localparam int CFG_W       = 16;
   localparam int FUNC_W      = 2;
   localparam int PHASE_OUT_W = 2;

   // default geometry
   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int NUM_PHASES_DEF    = 4;

   // interval register value after reset
   localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd1000;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_STATS   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ELAPSED = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

endpackage

// ----- hw/rtl/tick_phase_scheduler_with_stats.sv -----
// ----------------------------------------------------------------------------
// tick_phase_scheduler_with_stats
// tick scheduler with round robin phases and per-phase sample statistics
// ----------------------------------------------------------------------------
// usage
//   req channel (valid/ready) carries one item: func and counter_sample.
//     tick     adds the interval to the 32-bit total, serves the next phase
//              and stores the sample in that phase's history ring
//     stats    returns one row per phase (max, min, truncated mean), last
//              flag on the final row
//     elapsed  returns time since the previous elapsed item, moves reference
//     func 3 is dropped with no result
//   rsp channel (valid/ready) is a registered output stage; the block keeps
//   working on the next stats row while a row waits to be taken
//   csr port writes the tick interval (microseconds) whenever enabled
// sequence
//   tick and elapsed: accept, then load the rsp register
//   stats: accept, then per row the history ram read port gives one sample
//   per cycle, then the last read data is folded in, the mean is formed by
//   a reciprocal multiply and the row is loaded into the rsp register once
//   the stage is free
// reset
//   sync active high; afterwards a clearing pass writes zero to all
//   NUM_PHASES * HISTORY_DEPTH ram entries, one per cycle, with req_ready low
//   a stalled rsp just holds; the next stats row waits until the stage frees
// ----------------------------------------------------------------------------
module tick_phase_scheduler_with_stats #(
   parameter int HISTORY_DEPTH = tps_pkg::HISTORY_DEPTH_DEF,
   parameter int NUM_PHASES    = tps_pkg::NUM_PHASES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tps_pkg::FUNC_W-1:0]       req_func,
   input  logic [tps_pkg::SAMPLE_W-1:0]     req_counter_sample,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tps_pkg::PHASE_OUT_W-1:0]  rsp_phase,
   output logic [tps_pkg::TIME_W-1:0]       rsp_total_us,
   output logic [tps_pkg::TIME_W-1:0]       rsp_elapsed_us,
   output logic [tps_pkg::SAMPLE_W-1:0]     rsp_stat_max,
   output logic [tps_pkg::SAMPLE_W-1:0]     rsp_stat_min,
   output logic [tps_pkg::SAMPLE_W-1:0]     rsp_stat_avg,
   output logic                             rsp_last,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [tps_pkg::CFG_W-1:0]        csr_wr_data
);

   localparam int SW        = tps_pkg::SAMPLE_W;
   localparam int TW        = tps_pkg::TIME_W;
   localparam int CW        = tps_pkg::CFG_W;
   localparam int MEM_DEPTH = NUM_PHASES * HISTORY_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int IDX_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int PH_W      = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
   // ring sum stays below HISTORY_DEPTH * 2^16
   localparam int LOG_D     = $clog2(HISTORY_DEPTH);
   localparam int SUM_W     = SW + LOG_D;
   // mean as sum * ceil(2^SHIFT / depth) >> SHIFT, exact for sums below 2^SUM_W
   localparam int SHIFT     = SUM_W + LOG_D;
   localparam int RECIP_W   = SUM_W + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;

   localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [PH_W-1:0]    PHASE_LAST = PH_W'(NUM_PHASES - 1);
   localparam logic [ADDR_W-1:0]  ADDR_LAST  = ADDR_W'(MEM_DEPTH - 1);
   localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(((64'd1 << SHIFT)
      + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

   // controller states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   // control and architectural state
   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [CW-1:0]      interval_ff, interval_in;
   logic [TW-1:0]      total_ff, total_in;
   logic [TW-1:0]      ref_ff, ref_in;
   logic [PH_W-1:0]    phase_ff, phase_in;
   logic [IDX_W-1:0]   ring_pos_ff [NUM_PHASES];
   logic [IDX_W-1:0]   ring_pos_in [NUM_PHASES];

   // stats walk
   logic [PH_W-1:0]    row_ff, row_in;
   logic [ADDR_W-1:0]  walk_addr_ff, walk_addr_in;
   logic [IDX_W-1:0]   walk_idx_ff, walk_idx_in;
   logic               walk_issue_ff, walk_issue_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_last_ff, rd_last_in;
   logic [SW-1:0]      acc_max_ff, acc_max_in;
   logic [SW-1:0]      acc_min_ff, acc_min_in;
   logic [SUM_W-1:0]   acc_sum_ff, acc_sum_in;

   // mean by reciprocal multiply
   logic [SUM_W-1:0]   div_sum_ff, div_sum_in;
   logic [PROD_W-1:0]  avg_prod;

   // result waiting for the output stage
   logic [tps_pkg::PHASE_OUT_W-1:0] pend_phase_ff, pend_phase_in;
   logic [TW-1:0]      pend_elapsed_ff, pend_elapsed_in;
   logic [SW-1:0]      pend_max_ff, pend_max_in;
   logic [SW-1:0]      pend_min_ff, pend_min_in;
   logic [SW-1:0]      pend_avg_ff, pend_avg_in;
   logic               pend_last_ff, pend_last_in;

   // output stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic [tps_pkg::PHASE_OUT_W-1:0] rsp_phase_ff;
   logic [TW-1:0]      rsp_total_ff;
   logic [TW-1:0]      rsp_elapsed_ff;
   logic [SW-1:0]      rsp_max_ff;
   logic [SW-1:0]      rsp_min_ff;
   logic [SW-1:0]      rsp_avg_ff;
   logic               rsp_last_ff;
   logic               rsp_load;
   logic               out_free;

   // history ram port signals
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [SW-1:0]      mem_wr_data;
   logic               mem_rd_en;
   logic [SW-1:0]      mem_rd_data;

   // helpers
   logic [IDX_W-1:0]   cur_pos;
   logic [IDX_W-1:0]   next_pos;
   logic [ADDR_W-1:0]  tick_addr;
   logic [SW-1:0]      upd_max;
   logic [SW-1:0]      upd_min;
   logic [SUM_W-1:0]   upd_sum;

   // all phase rings in one ram, phase p at rows p*HISTORY_DEPTH onward
   tps_ram #(
      .WIDTH (SW),
      .DEPTH (MEM_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (walk_addr_ff),
      .rd_data (mem_rd_data)
   );

   // next slot of the served phase's ring, wraps after the last slot
   assign cur_pos   = ring_pos_ff[phase_ff];
   assign next_pos  = (cur_pos == IDX_LAST) ? '0 : cur_pos + 1'b1;
   assign tick_addr = ADDR_W'(32'(phase_ff) * HISTORY_DEPTH) + ADDR_W'(next_pos);

   // running max, min and sum over the sample coming back from the ram
   assign upd_max = (mem_rd_data > acc_max_ff) ? mem_rd_data : acc_max_ff;
   assign upd_min = (mem_rd_data < acc_min_ff) ? mem_rd_data : acc_min_ff;
   assign upd_sum = acc_sum_ff + SUM_W'(mem_rd_data);

   // truncated mean, quotient sits at bit SHIFT of the product
   assign avg_prod = PROD_W'(div_sum_ff) * PROD_W'(RECIP);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      interval_in     = interval_ff;
      total_in        = total_ff;
      ref_in          = ref_ff;
      phase_in        = phase_ff;
      ring_pos_in     = ring_pos_ff;
      row_in          = row_ff;
      walk_addr_in    = walk_addr_ff;
      walk_idx_in     = walk_idx_ff;
      walk_issue_in   = walk_issue_ff;
      rd_vld_in       = 1'b0;
      rd_last_in      = 1'b0;
      acc_max_in      = acc_max_ff;
      acc_min_in      = acc_min_ff;
      acc_sum_in      = acc_sum_ff;
      div_sum_in      = div_sum_ff;
      pend_phase_in   = pend_phase_ff;
      pend_elapsed_in = pend_elapsed_ff;
      pend_max_in     = pend_max_ff;
      pend_min_in     = pend_min_ff;
      pend_avg_in     = pend_avg_ff;
      pend_last_in    = pend_last_ff;
      rsp_load        = 1'b0;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = clr_addr_ff;
      mem_wr_data     = '0;
      mem_rd_en       = 1'b0;

      // interval register may be written at any time
      if (csr_wr_en) begin
         interval_in = csr_wr_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            // zero one ram entry per cycle after reset
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  tps_pkg::FUNC_TICK: begin
                     total_in              = total_ff + TW'(interval_ff);
                     ring_pos_in[phase_ff] = next_pos;
                     mem_wr_en             = 1'b1;
                     mem_wr_addr           = tick_addr;
                     mem_wr_data           = req_counter_sample;
                     phase_in              = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 1'b1;
                     pend_phase_in         = tps_pkg::PHASE_OUT_W'(phase_ff);
                     pend_elapsed_in       = '0;
                     pend_max_in           = '0;
                     pend_min_in           = '0;
                     pend_avg_in           = '0;
                     pend_last_in          = 1'b1;
                     state_in              = ST_EMIT;
                  end
                  tps_pkg::FUNC_STATS: begin
                     row_in        = '0;
                     walk_addr_in  = '0;
                     walk_idx_in   = '0;
                     walk_issue_in = 1'b1;
                     acc_max_in    = '0;
                     acc_min_in    = '1;
                     acc_sum_in    = '0;
                     state_in      = ST_WALK;
                  end
                  tps_pkg::FUNC_ELAPSED: begin
                     pend_elapsed_in = total_ff - ref_ff;
                     ref_in          = total_ff;
                     pend_phase_in   = '0;
                     pend_max_in     = '0;
                     pend_min_in     = '0;
                     pend_avg_in     = '0;
                     pend_last_in    = 1'b1;
                     state_in        = ST_EMIT;
                  end
                  default: begin
                     // unused code, item dropped
                  end
               endcase
            end
         end
         ST_WALK: begin
            // issue one read per cycle across the current row
            if (walk_issue_ff) begin
               mem_rd_en    = 1'b1;
               rd_vld_in    = 1'b1;
               walk_addr_in = walk_addr_ff + 1'b1;
               if (walk_idx_ff == IDX_LAST) begin
                  rd_last_in    = 1'b1;
                  walk_issue_in = 1'b0;
               end else begin
                  walk_idx_in = walk_idx_ff + 1'b1;
               end
            end
            // fold in data returned in the cycle after its read
            if (rd_vld_ff) begin
               acc_max_in = upd_max;
               acc_min_in = upd_min;
               acc_sum_in = upd_sum;
            end
            if (rd_last_ff) begin
               div_sum_in = upd_sum;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            pend_phase_in   = tps_pkg::PHASE_OUT_W'(row_ff);
            pend_elapsed_in = '0;
            pend_max_in     = acc_max_ff;
            pend_min_in     = acc_min_ff;
            pend_avg_in     = avg_prod[SHIFT +: SW];
            pend_last_in    = (row_ff == PHASE_LAST);
            state_in        = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for the output stage, then go idle after the last item or move on to the next row
            if (out_free) begin
               rsp_load = 1'b1;
               if (pend_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in        = row_ff + 1'b1;
                  walk_idx_in   = '0;
                  walk_issue_in = 1'b1;
                  acc_max_in    = '0;
                  acc_min_in    = '1;
                  acc_sum_in    = '0;
                  state_in      = ST_WALK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         interval_ff   <= tps_pkg::INTERVAL_RESET;
         total_ff      <= '0;
         ref_ff        <= '0;
         phase_ff      <= '0;
         for (int p = 0; p < NUM_PHASES; p++) begin
            ring_pos_ff[p] <= IDX_LAST;
         end
         walk_issue_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         interval_ff   <= interval_in;
         total_ff      <= total_in;
         ref_ff        <= ref_in;
         phase_ff      <= phase_in;
         ring_pos_ff   <= ring_pos_in;
         walk_issue_ff <= walk_issue_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      row_ff          <= row_in;
      walk_addr_ff    <= walk_addr_in;
      walk_idx_ff     <= walk_idx_in;
      acc_max_ff      <= acc_max_in;
      acc_min_ff      <= acc_min_in;
      acc_sum_ff      <= acc_sum_in;
      div_sum_ff      <= div_sum_in;
      pend_phase_ff   <= pend_phase_in;
      pend_elapsed_ff <= pend_elapsed_in;
      pend_max_ff     <= pend_max_in;
      pend_min_ff     <= pend_min_in;
      pend_avg_ff     <= pend_avg_in;
      pend_last_ff    <= pend_last_in;
      if (rsp_load) begin
         rsp_phase_ff   <= pend_phase_ff;
         rsp_total_ff   <= total_ff;
         rsp_elapsed_ff <= pend_elapsed_ff;
         rsp_max_ff     <= pend_max_ff;
         rsp_min_ff     <= pend_min_ff;
         rsp_avg_ff     <= pend_avg_ff;
         rsp_last_ff    <= pend_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_phase      = rsp_phase_ff;
   assign rsp_total_us   = rsp_total_ff;
   assign rsp_elapsed_us = rsp_elapsed_ff;
   assign rsp_stat_max   = rsp_max_ff;
   assign rsp_stat_min   = rsp_min_ff;
   assign rsp_stat_avg   = rsp_avg_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- hw/rtl/tps_ram.sv -----
// ----------------------------------------------------------------------------
// tps_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tps_ram #(
   parameter int WIDTH = tps_pkg::SAMPLE_W,
   parameter int DEPTH = tps_pkg::NUM_PHASES_DEF * tps_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tps_checker.sv -----
// ----------------------------------------------------------------------------
// tps_checker
// port level checks of the tick phase scheduler, bound to the top level
// ----------------------------------------------------------------------------
module tps_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [tps_pkg::FUNC_W-1:0]       req_func,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tps_pkg::PHASE_OUT_W-1:0]  rsp_phase,
   input logic [tps_pkg::TIME_W-1:0]       rsp_total_us,
   input logic [tps_pkg::TIME_W-1:0]       rsp_elapsed_us,
   input logic [tps_pkg::SAMPLE_W-1:0]     rsp_stat_max,
   input logic [tps_pkg::SAMPLE_W-1:0]     rsp_stat_min,
   input logic [tps_pkg::SAMPLE_W-1:0]     rsp_stat_avg,
   input logic                             rsp_last
);

   // no item shows right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a stalled item holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
         && $stable(rsp_total_us) && $stable(rsp_elapsed_us)
         && $stable(rsp_stat_max) && $stable(rsp_stat_min)
         && $stable(rsp_stat_avg) && $stable(rsp_last))
      else $error("stalled rsp item changed");

   // mean lies between minimum and maximum on every row
   a_stat_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stat_min <= rsp_stat_avg && rsp_stat_avg <= rsp_stat_max)
      else $error("stat row out of order");

   // elapsed time only on a single final item
   a_elapsed_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_elapsed_us != '0 |-> rsp_last)
      else $error("elapsed item without last");

   // an item that does work keeps the request side closed in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func != tps_pkg::FUNC_NONE |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind tick_phase_scheduler_with_stats tps_checker u_tps_checker (.*);
